// ===== design/hfs_pkg.sv =====
package hfs_pkg;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP,
    S_DENORM,
    S_NORM,
    S_ROUND,
    S_PACK
  } hfs_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;        // one character item accepted
    logic load;        // value finished: move accumulators into the work registers
    logic calc_e;      // add binary exponent and bias
    logic denorm_step; // one right shift into round and sticky
    logic denorm_end;  // clamp exponent after the right shifts
    logic norm_step;   // one left shift
    logic round;       // apply rounding increment
    logic pack;        // write the output register
  } hfs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_nz;    // right shifts still pending
    logic norm_left; // significand not yet normalized
    logic out_free;  // output register can take a result
  } hfs_status_t;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  localparam int          DIGIT_BITS = 4;
  localparam logic [7:0]  DIGIT_TEN  = 8'd10;

  // rounding modes
  localparam logic [2:0] RM_NEAR_EVEN = 3'd0;
  localparam logic [2:0] RM_UP        = 3'd1;
  localparam logic [2:0] RM_DOWN      = 3'd2;
  localparam logic [2:0] RM_ZERO      = 3'd3;
  localparam logic [2:0] RM_HALF_AWAY = 3'd4;

endpackage

// ===== design/hex_float_string_to_binary.sv =====
// conversion: a character that ends a value starts the exponent step, the
// one-bit-per-cycle denormalize and normalize shift loops, rounding and packing
// before the result is in the output register; packing waits for a free output register
// throughput: one character per cycle outside conversion; no input during conversion
// reset: synchronous active-low rst_n clears accumulators, rounding mode and output valid
module hex_float_string_to_binary #(
  parameter int PRECISION     = 53,
  parameter int EXPONENT_BITS = 11,
  parameter int MAX_DIGITS    = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_first_char,
  input  logic               in_end_of_value,
  input  logic signed [14:0] in_binary_exponent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_result_bits,
  output logic               out_inexact,
  output logic               out_bad_character,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_write_data
);
  import hfs_pkg::*;

  hfs_cmd_t    cmd;
  hfs_status_t st;
  hfs_state_t  state;

  // sequencer
  hfs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_end_of_value (in_end_of_value),
    .in_ready        (in_ready),
    .st              (st),
    .cmd             (cmd),
    .state           (state)
  );

  // accumulate, convert and pack
  hfs_datapath #(
    .PRECISION     (PRECISION),
    .EXPONENT_BITS (EXPONENT_BITS),
    .MAX_DIGITS    (MAX_DIGITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_char_code       (in_char_code),
    .in_first_char      (in_first_char),
    .in_binary_exponent (in_binary_exponent),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_bits    (out_result_bits),
    .out_inexact        (out_inexact),
    .out_bad_character  (out_bad_character)
  );

`ifndef SYNTHESIS
  // a finished value always starts the exponent step
  a_load_to_exp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_value |=> state == S_EXP)
    else $error("conversion did not start");

  // a new result only comes out of the pack state
  a_rise_from_pack: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state == S_PACK))
    else $error("result appeared without pack");

  // infinity carries no fraction bits
  a_inf_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (&out_result_bits[EXPONENT_BITS+PRECISION-2:PRECISION-1])
    |-> out_result_bits[PRECISION-2:0] == '0)
    else $error("infinity with fraction");
`endif

endmodule

// ===== design/hfs_ctrl.sv =====
module hfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_end_of_value,
  output logic                in_ready,
  input  hfs_pkg::hfs_status_t st,
  output hfs_pkg::hfs_cmd_t    cmd,
  output hfs_pkg::hfs_state_t  state
);
  import hfs_pkg::*;

  hfs_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_end_of_value) state_nxt = S_EXP;
      end
      S_EXP:    state_nxt = S_DENORM;
      S_DENORM: begin
        if (!st.cnt_nz) state_nxt = S_NORM;
      end
      S_NORM: begin
        if (!st.norm_left) state_nxt = S_ROUND;
      end
      S_ROUND:  state_nxt = S_PACK;
      S_PACK: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        cmd.load = in_valid && in_end_of_value;
      end
      S_EXP:    cmd.calc_e = 1'b1;
      S_DENORM: begin
        cmd.denorm_step = st.cnt_nz;
        cmd.denorm_end  = !st.cnt_nz;
      end
      S_NORM:   cmd.norm_step = st.norm_left;
      S_ROUND:  cmd.round = 1'b1;
      S_PACK:   cmd.pack = st.out_free;
      default:  cmd = '0;
    endcase
  end

  assign state = state_r;

endmodule

// ===== design/hfs_datapath.sv =====
module hfs_datapath #(
  parameter int PRECISION     = 53,
  parameter int EXPONENT_BITS = 11,
  parameter int MAX_DIGITS    = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hfs_pkg::hfs_cmd_t    cmd,
  output hfs_pkg::hfs_status_t st,
  input  logic [7:0]           in_char_code,
  input  logic                 in_first_char,
  input  logic signed [14:0]   in_binary_exponent,
  input  logic                 cfg_write_en,
  input  logic [2:0]           cfg_write_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_result_bits,
  output logic                 out_inexact,
  output logic                 out_bad_character
);
  import hfs_pkg::*;

  localparam int P    = PRECISION;
  localparam int EW   = 22;
  localparam int AW   = 20;
  localparam int CW   = $clog2(P + 2);
  localparam int EMAX = (1 << EXPONENT_BITS) - 1;
  localparam int BIAS = (1 << (EXPONENT_BITS - 1)) - 1;
  localparam int EOFF = P - 1 + BIAS;
  localparam logic signed [AW-1:0] LIM  = AW'(-(DIGIT_BITS * MAX_DIGITS));
  localparam logic signed [EW-1:0] CAP  = EW'(P + 1);

  // accumulators
  logic [P-1:0]          acc_f_r;
  logic signed [AW-1:0]  acc_e_r;
  logic                  acc_rnd_r, acc_stk_r, acc_neg_r, acc_stop_r, acc_junk_r;
  // work registers for conversion
  logic [P-1:0]          wf_r;
  logic signed [EW-1:0]  we_r;
  logic                  wrnd_r, wstk_r, wneg_r, wjunk_r, wfz_r;
  logic signed [14:0]    bexp_r;
  logic [CW-1:0]         cnt_r;
  logic [2:0]            mode_r;
  // output register
  logic                  out_valid_r;
  logic [63:0]           res_r;
  logic                  inx_r, bad_r;

  // character step signals
  logic [P-1:0]          b_f, n_f;
  logic signed [AW-1:0]  b_e, n_e;
  logic                  b_r, b_s, b_neg, b_stop, b_junk;
  logic                  n_r, n_s, n_neg, n_stop, n_junk;
  logic                  is_dig;
  logic [3:0]            dig;
  logic [P+3:0]          wide;
  logic [2:0]            k;

  // one character into the accumulators
  always_comb begin
    b_f    = in_first_char ? '0 : acc_f_r;
    b_e    = in_first_char ? '0 : acc_e_r;
    b_r    = in_first_char ? 1'b0 : acc_rnd_r;
    b_s    = in_first_char ? 1'b0 : acc_stk_r;
    b_neg  = in_first_char ? 1'b0 : acc_neg_r;
    b_stop = in_first_char ? 1'b0 : acc_stop_r;
    b_junk = in_first_char ? 1'b0 : acc_junk_r;
    n_f = b_f; n_e = b_e; n_r = b_r; n_s = b_s;
    n_neg = b_neg; n_stop = b_stop; n_junk = b_junk;
    is_dig = 1'b0;
    dig    = '0;
    wide   = {b_f, 4'd0};
    k      = '0;
    if (in_first_char && in_char_code == CH_MINUS) begin
      n_neg = 1'b1;
    end else if (!b_stop) begin
      if (in_char_code == CH_NUL) begin
        n_stop = 1'b1;
      end else if (in_char_code inside {[CH_0:CH_9]}) begin
        is_dig = 1'b1;
        dig    = 4'(in_char_code - CH_0);
      end else if (in_char_code inside {[CH_A:CH_F]}) begin
        is_dig = 1'b1;
        dig    = 4'(in_char_code - CH_A + DIGIT_TEN);
      end else begin
        n_junk = 1'b1;
        n_stop = 1'b1;
      end
      // leading zeros past the limit are dropped
      if (is_dig && !(dig == 4'd0 && b_f == '0 && b_e <= LIM)) begin
        wide = {b_f, dig};
        if (wide[P+3])      k = 3'd4;
        else if (wide[P+2]) k = 3'd3;
        else if (wide[P+1]) k = 3'd2;
        else if (wide[P])   k = 3'd1;
        else                k = 3'd0;
        case (k)
          3'd1: begin
            n_f = wide[P:1];   n_r = wide[0]; n_s = b_s | b_r;
          end
          3'd2: begin
            n_f = wide[P+1:2]; n_r = wide[1]; n_s = b_s | b_r | wide[0];
          end
          3'd3: begin
            n_f = wide[P+2:3]; n_r = wide[2]; n_s = b_s | b_r | (|wide[1:0]);
          end
          3'd4: begin
            n_f = wide[P+3:4]; n_r = wide[3]; n_s = b_s | b_r | (|wide[2:0]);
          end
          default: n_f = wide[P-1:0];
        endcase
        n_e = b_e - AW'(DIGIT_BITS) + $signed({{(AW-3){1'b0}}, k});
      end
    end
  end

  // accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_f_r <= '0; acc_e_r <= '0; acc_rnd_r <= 1'b0; acc_stk_r <= 1'b0;
      acc_neg_r <= 1'b0; acc_stop_r <= 1'b0; acc_junk_r <= 1'b0;
    end else if (cmd.load) begin
      acc_f_r <= '0; acc_e_r <= '0; acc_rnd_r <= 1'b0; acc_stk_r <= 1'b0;
      acc_neg_r <= 1'b0; acc_stop_r <= 1'b0; acc_junk_r <= 1'b0;
    end else if (cmd.take) begin
      acc_f_r <= n_f; acc_e_r <= n_e; acc_rnd_r <= n_r; acc_stk_r <= n_s;
      acc_neg_r <= n_neg; acc_stop_r <= n_stop; acc_junk_r <= n_junk;
    end
  end

  // rounding mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RM_NEAR_EVEN;
    end else if (cfg_write_en) begin
      mode_r <= cfg_write_data;
    end
  end

  // conversion datapath
  logic signed [EW-1:0] e_sum, one_minus_e;
  logic [CW-1:0]        cnt_ld;
  logic                 inc;
  logic [P:0]           f_inc;

  always_comb begin
    e_sum       = we_r + EW'(bexp_r) + EW'(EOFF);
    one_minus_e = EW'(1) - e_sum;
    if (wfz_r || e_sum > EW'(0)) cnt_ld = '0;
    else if (one_minus_e > CAP)  cnt_ld = CW'(P + 1);
    else                         cnt_ld = one_minus_e[CW-1:0];
    case (mode_r)
      RM_NEAR_EVEN: inc = wrnd_r && (wstk_r || wf_r[0]);
      RM_UP:        inc = !wneg_r && (wrnd_r || wstk_r);
      RM_DOWN:      inc = wneg_r && (wrnd_r || wstk_r);
      RM_HALF_AWAY: inc = wrnd_r;
      default:      inc = 1'b0;
    endcase
    f_inc = {1'b0, wf_r} + (P+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wf_r    <= n_f;
      we_r    <= EW'(n_e);
      wrnd_r  <= n_r;
      wstk_r  <= n_s;
      wneg_r  <= n_neg;
      wjunk_r <= n_junk;
      wfz_r   <= (n_f == '0);
      bexp_r  <= in_binary_exponent;
    end else if (cmd.calc_e) begin
      we_r  <= e_sum;
      cnt_r <= cnt_ld;
    end else if (cmd.denorm_step) begin
      wstk_r <= wstk_r | wrnd_r;
      wrnd_r <= wf_r[0];
      wf_r   <= wf_r >> 1;
      cnt_r  <= cnt_r - CW'(1);
    end else if (cmd.denorm_end) begin
      if (!wfz_r && we_r < EW'(1)) we_r <= EW'(1);
    end else if (cmd.norm_step) begin
      wf_r <= wf_r << 1;
      we_r <= we_r - EW'(1);
    end else if (cmd.round) begin
      if (!wfz_r && inc) begin
        if (f_inc[P]) begin
          wf_r <= f_inc[P:1];
          we_r <= we_r + EW'(1);
        end else begin
          wf_r <= f_inc[P-1:0];
        end
      end
    end
  end

  // packing
  logic [EXPONENT_BITS-1:0] e_fld;
  logic [P-2:0]             frac;
  always_comb begin
    e_fld = we_r[EXPONENT_BITS-1:0];
    frac  = wf_r[P-2:0];
    if (wf_r == '0 || (we_r == EW'(1) && !wf_r[P-1])) begin
      e_fld = '0;
    end else if (we_r >= EW'(EMAX)) begin
      e_fld = EXPONENT_BITS'(EMAX);
      frac  = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pack) begin
      res_r <= (64'(wneg_r) << (EXPONENT_BITS + P - 1))
             | (64'(e_fld) << (P - 1))
             | 64'(frac);
      inx_r <= wrnd_r | wstk_r;
      bad_r <= wjunk_r;
    end
  end

  assign st.cnt_nz    = (cnt_r != '0);
  assign st.norm_left = !wfz_r && (we_r > EW'(1)) && !wf_r[P-1];
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_result_bits   = res_r;
  assign out_inexact       = inx_r;
  assign out_bad_character = bad_r;

endmodule

// ===== dv/hex_float_string_to_binary_tb.sv =====
module hex_float_string_to_binary_tb;
  import hfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PREC = 53;
  localparam int EBITS = 11;
  localparam int MAXD = 1024;
  localparam int BIAS = (1 << (EBITS - 1)) - 1;
  localparam int EMAX = (1 << EBITS) - 1;
  localparam int SETTLE = PREC + 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_char_code;
  logic in_first_char;
  logic in_end_of_value;
  logic signed [14:0] in_binary_exponent;
  logic out_valid;
  logic out_ready;
  logic [63:0] out_result_bits;
  logic out_inexact;
  logic out_bad_character;
  logic cfg_write_en;
  logic [2:0] cfg_write_data;

  hex_float_string_to_binary dut (.*);

  typedef struct packed {
    logic [63:0] bits;
    logic inexact;
    logic bad;
  } conv_result_t;

  conv_result_t pending_results[$];
  int errors;
  int results_seen;
  int values_sent;
  bit in_noidle;
  bit out_noidle;
  bit out_hold;

  // predictor state
  logic [63:0] sig_acc;
  int exp_adj;
  bit rnd_b;
  bit stk_b;
  bit neg_b;
  bit stopped_b;
  bit junk_b;
  logic [2:0] rmode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("timeout at %0t", $time);
    $display("TEST FAILED");
    $finish;
  end

  function automatic void clear_value();
    sig_acc = '0;
    exp_adj = 0;
    rnd_b = 0;
    stk_b = 0;
    neg_b = 0;
    stopped_b = 0;
    junk_b = 0;
  endfunction

  function automatic void shr1(ref logic [63:0] f);
    stk_b = stk_b | rnd_b;
    rnd_b = f[0];
    f = f >> 1;
  endfunction

  // accumulate one character into the significand
  function automatic void absorb_char(logic [7:0] c);
    logic [3:0] d;
    if (stopped_b) return;
    if (c == CH_NUL) begin
      stopped_b = 1;
      return;
    end
    if (c >= CH_0 && c <= CH_9) d = 4'(c - CH_0);
    else if (c >= CH_A && c <= CH_F) d = 4'(c - CH_A + DIGIT_TEN);
    else begin
      junk_b = 1;
      stopped_b = 1;
      return;
    end
    if (d == 0 && sig_acc == 0 && exp_adj <= -(DIGIT_BITS * MAXD)) return;
    sig_acc = (sig_acc << DIGIT_BITS) | 64'(d);
    exp_adj -= DIGIT_BITS;
    while ((sig_acc >> PREC) != 0) begin
      shr1(sig_acc);
      exp_adj += 1;
    end
  endfunction

  // finish a value: denormalize/normalize, round, pack
  function automatic logic [63:0] pack_value(int bexp);
    logic [63:0] f;
    logic [63:0] top;
    logic [63:0] sgn;
    int e;
    int n;
    bit inc;
    bit lost;
    f = sig_acc;
    e = bexp + (PREC - 1) + BIAS + exp_adj;
    top = 64'd1 << (PREC - 1);
    sgn = neg_b ? (64'd1 << (EBITS + PREC - 1)) : 64'd0;
    if (f != 0) begin
      inc = 0;
      if (e < 1) begin
        n = 1 - e;
        if (n > PREC + 1) n = PREC + 1;
        repeat (n) shr1(f);
        e = 1;
      end
      while (e > 1 && (f & top) == 0) begin
        f = f << 1;
        e -= 1;
      end
      lost = rnd_b | stk_b;
      case (rmode)
        RM_NEAR_EVEN: inc = rnd_b && (stk_b || f[0]);
        RM_UP: inc = !neg_b && lost;
        RM_DOWN: inc = neg_b && lost;
        RM_HALF_AWAY: inc = rnd_b;
        default: inc = 0;
      endcase
      if (inc) begin
        f += 1;
        if ((f >> PREC) != 0) begin
          f = f >> 1;
          e += 1;
        end
      end
    end
    if (f == 0) e = 0;
    else if (e == 1 && (f & top) == 0) e = 0;
    else if (e >= EMAX) begin
      e = EMAX;
      f = 0;
    end else f = f & (top - 1);
    return sgn | (64'(e) << (PREC - 1)) | f;
  endfunction

  function automatic void predict_char(logic [7:0] c, bit first, bit eov, logic [14:0] be);
    conv_result_t r;
    if (first) clear_value();
    if (first && c == CH_MINUS) neg_b = 1;
    else absorb_char(c);
    if (eov) begin
      r.bits = pack_value(int'($signed(be)));
      r.inexact = rnd_b | stk_b;
      r.bad = junk_b;
      pending_results.push_back(r);
      clear_value();
    end
  endfunction

  // send one character item; valid drops only while idling
  task automatic send_char(logic [7:0] c, bit first, bit eov, logic [14:0] be);
    while (!in_noidle && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_first_char <= first;
    in_end_of_value <= eov;
    in_binary_exponent <= be;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(c, first, eov, be);
    if (eov) values_sent++;
  endtask

  // a whole value: optional minus, digits, terminator carrying exponent
  task automatic send_value(bit neg, string digs, int be);
    bit first;
    first = 1;
    if (neg) begin
      send_char(CH_MINUS, 1, 0, '0);
      first = 0;
    end
    for (int i = 0; i < digs.len(); i++) begin
      send_char(digs[i], first, 0, '0);
      first = 0;
    end
    send_char(CH_NUL, first, 1, 15'(be));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(logic [2:0] m);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    rmode = m;
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    conv_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_result_bits);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.bits !== out_result_bits) begin
          $display("%0t bits exp %h got %h", $time, exp_r.bits, out_result_bits);
          errors++;
        end
        if (exp_r.inexact !== out_inexact) begin
          $display("%0t inexact exp %b got %b", $time, exp_r.inexact, out_inexact);
          errors++;
        end
        if (exp_r.bad !== out_bad_character) begin
          $display("%0t bad_character exp %b got %b", $time, exp_r.bad, out_bad_character);
          errors++;
        end
      end
    end
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (out_hold) out_ready <= 1'b0;
    else if (out_noidle) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 12);
  end

  function automatic string rand_digits(int n);
    string s;
    byte hexc[16] = '{"0","1","2","3","4","5","6","7","8","9","A","B","C","D","E","F"};
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(hexc[$urandom_range(15)])};
    return s;
  endfunction

  task automatic test_directed();
    send_value(0, "1", 0);
    send_value(1, "1", 0);
    send_value(0, "0", 0);
    send_value(1, "0", 5);
    send_value(0, "FFFFFFFFFFFFFFFF", 0);
    send_value(0, "123456789ABCDEF", -16384);
    send_value(0, "ABCDEF", 16383);
    send_value(1, "FFFFFFFFFFFFF8", -1074);
    send_value(0, "1", -1074);
    send_value(0, "1", -1075);
    send_value(0, "3", -1076);
    send_value(0, "1FFFFFFFFFFFFF8", 970);
    send_value(0, "1", 1024);
    // bad characters, late minus, lowercase
    send_char("1", 1, 0, '0);
    send_char("-", 0, 0, '0);
    send_char("2", 0, 1, 15'd0);
    send_char("a", 1, 1, 15'd3);
    send_char("7", 1, 0, '0);
    send_char(CH_NUL, 0, 0, '0);
    send_char("9", 0, 1, 15'd1);
    // single char first and end together
    send_char("F", 1, 1, 15'h7FFF);
  endtask

  // ties, subnormal rounding and overflow in every rounding code
  task automatic test_modes();
    for (int m = 0; m < 8; m++) begin
      set_mode(3'(m));
      send_value(0, "1FFFFFFFFFFFFF8", 0);
      send_value(1, "3", -1076);
      send_value(0, "1", -1075);
      send_value(1, "3", -1075);
      send_value(0, "FFFFFFFFFFFFFFFF", 960);
    end
  endtask

  // n counts character items
  task automatic test_random(int n);
    int k;
    int kind;
    int be;
    bit neg;
    string digs;
    k = 0;
    while (k < n) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        // well-formed value, exponents near interesting ranges
        case ($urandom_range(3))
          0: be = $urandom_range(120) - 60;
          1: be = -1075 - $urandom_range(80) + 40;
          2: be = 1023 - $urandom_range(80);
          default: be = int'($urandom_range(32767)) - 16384;
        endcase
        neg = $urandom_range(1);
        digs = rand_digits($urandom_range(1, 18));
        send_value(neg, digs, be);
        k += 1 + int'(neg) + digs.len();
      end else begin
        // raw noise character
        send_char(8'($urandom), $urandom_range(1), $urandom_range(3) == 0,
                  15'($urandom));
        k += 1;
      end
      if ($urandom_range(60) == 0) set_mode(3'($urandom_range(7)));
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        out_hold = 1;
        repeat (300) @(posedge clk);
        out_hold = 0;
      end
      begin
        for (int i = 0; i < 20; i++) send_value(0, rand_digits(3), $urandom_range(40));
        in_valid <= 1'b0;
      end
    join
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    values_sent = 0;
    in_noidle = 0;
    out_noidle = 0;
    out_hold = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = '0;
    in_first_char = 1'b0;
    in_end_of_value = 1'b0;
    in_binary_exponent = '0;
    out_ready = 1'b0;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    rmode = RM_NEAR_EVEN;
    clear_value();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_modes();
    set_mode(RM_NEAR_EVEN);
    test_backpressure();
    in_noidle = 1;
    out_noidle = 1;
    test_random(120);
    in_noidle = 0;
    out_noidle = 0;
    test_random(120);
    set_mode(RM_HALF_AWAY);
    test_random(60);
    drain();
    $display("covered %0d values, %0d results checked, all rounding codes, stalls",
             values_sent, results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
